[rtl/source_dest_route_table_top_assert.svh]
// Assertion macros shared by the route table RTL.
`ifndef SOURCE_DEST_ROUTE_TABLE_TOP_ASSERT_SVH
`define SOURCE_DEST_ROUTE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/srt_pkg.sv]
// Types, constants and helper functions of the route table.
package srt_pkg;

    localparam int ROUTE_SLOTS = 64;
    localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CNT_W = $clog2(ROUTE_SLOTS + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_LOOKUP_SRC = 2'd2;
    localparam logic [1:0] OP_LOOKUP_ANY = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int IN_W = 456;
    localparam int OUT_W = 200;

    typedef struct packed {
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [63:0] gw_hi;
        logic [63:0] gw_lo;
        logic [7:0]  src_len;
        logic [7:0]  dst_len;
        logic [31:0] metric;
        logic [15:0] iface;
        logic        onlink;
    } route_t;

    typedef struct packed {
        logic qualify;
        logic better;
        logic same;
    } eval_t;

    // True when the prefix covers the address; lengths above 128 act as 128.
    function automatic logic pfx_covers(input logic [127:0] pfx, input logic [7:0] plen,
                                        input logic [127:0] addr);
        logic [127:0] mask;
        begin
            if (plen >= 8'd128) begin
                mask = '1;
            end else begin
                mask = ~({128{1'b1}} >> plen);
            end
            pfx_covers = ((pfx ^ addr) & mask) == 128'd0;
        end
    endfunction

    // Strict ranking: true when a is preferred over b.
    function automatic logic rank_gt(input route_t a, input route_t b);
        logic [448:0] ka;
        logic [448:0] kb;
        begin
            ka = {a.dst_len, a.src_len, ~a.metric, a.onlink, a.iface,
                  a.src_hi, a.src_lo, a.dst_hi, a.dst_lo, a.gw_hi, a.gw_lo};
            kb = {b.dst_len, b.src_len, ~b.metric, b.onlink, b.iface,
                  b.src_hi, b.src_lo, b.dst_hi, b.dst_lo, b.gw_hi, b.gw_lo};
            rank_gt = ka > kb;
        end
    endfunction

endpackage

[rtl/srt_route_mem.sv]
// Route storage: one write port and one registered read port.
module srt_route_mem (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [srt_pkg::SLOT_W-1:0] wr_addr,
    input  srt_pkg::route_t            wr_data,
    input  logic [srt_pkg::SLOT_W-1:0] rd_addr,
    output srt_pkg::route_t            rd_data
);
    import srt_pkg::*;

    route_t mem [ROUTE_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/srt_rank_unit.sv]
// Shared compare unit: judges one stored route against the query and the best so far.
module srt_rank_unit (
    input  logic [1:0]       op,
    input  srt_pkg::route_t  cur,
    input  srt_pkg::route_t  top,
    input  logic             top_found,
    input  srt_pkg::route_t  key,
    input  logic [127:0]     q_src,
    input  logic [127:0]     q_dst,
    output srt_pkg::eval_t   res
);
    import srt_pkg::*;

    logic dst_ok;
    logic src_ok;

    assign dst_ok = pfx_covers({cur.dst_hi, cur.dst_lo}, cur.dst_len, q_dst);
    assign src_ok = (op == OP_LOOKUP_ANY) ||
                    pfx_covers({cur.src_hi, cur.src_lo}, cur.src_len, q_src);

    assign res.qualify = dst_ok && src_ok;
    assign res.better = !top_found || rank_gt(cur, top);
    // Stored routes keep a zero next hop when on-link, so full equality is identity.
    assign res.same = (cur == key);

endmodule

[rtl/source_dest_route_table_top.sv]
// Top level of the source-and-destination route table.
// Every transfer (add, delete or lookup) is handled by one scan over all ROUTE_SLOTS
// route slots, reading one stored route per cycle from a memory with one write port and
// one registered read port and passing it through one shared compare unit; the memory
// read port, one slot per cycle, sets the pace of the scan. s_tready is high only while
// the sequencer is idle; the result sits in an output register, so a new operation can
// be accepted while the previous result still waits for m_tready, and it completes once
// that register has been drained. Add stores into the lowest free slot unless an identical
// route exists, delete clears an identical route, and lookups return the best match by
// destination length, source length, metric, on-link, interface, then addresses.
module source_dest_route_table_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // From bit 0 up: op, src_hi, src_lo, src_len, dst_hi, dst_lo, dst_len,
    // out_iface, gw_hi, gw_lo, has_gateway, route_metric, zero fill.
    input  logic [srt_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // From bit 0 up: status, hit_iface, hit_gw_hi, hit_gw_lo, hit_onlink,
    // hit_metric, hit_dst_len, hit_src_len, zero fill.
    output logic [srt_pkg::OUT_W-1:0] m_tdata
);
    import srt_pkg::*;
    `include "source_dest_route_table_top_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_v_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [IN_W-1:0]  item_reg;
    route_t           best_reg;
    logic             best_found_reg;
    logic             free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic             match_found_reg;
    logic [SLOT_W-1:0] match_idx_reg;
    logic [ROUTE_SLOTS-1:0] valid_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] m_tdata_next;

    logic [1:0]   op;
    logic [127:0] q_src;
    logic [127:0] q_dst;
    logic [7:0]   in_src_len;
    logic [7:0]   in_dst_len;
    logic         in_has_gw;
    route_t       key;
    route_t       cur;
    eval_t        ev;
    logic         slot_live;
    logic         s_fire;
    logic         done_fire;
    logic         is_lookup;
    logic         wr_en;

    // Unpack the held request; the upper address half sits in the lower bits of s_tdata.
    assign op          = item_reg[1:0];
    assign q_src       = {item_reg[65:2], item_reg[129:66]};
    assign in_src_len  = item_reg[137:130];
    assign q_dst       = {item_reg[201:138], item_reg[265:202]};
    assign in_dst_len  = item_reg[273:266];
    assign in_has_gw   = item_reg[418];
    assign is_lookup   = (op == OP_LOOKUP_SRC) || (op == OP_LOOKUP_ANY);

    // The route as it would be stored: zero-length prefixes and on-link next hops are zeroed.
    always_comb begin
        key.src_len  = in_src_len;
        key.dst_len  = in_dst_len;
        key.src_hi   = (in_src_len != 8'd0) ? q_src[127:64] : 64'd0;
        key.src_lo   = (in_src_len != 8'd0) ? q_src[63:0] : 64'd0;
        key.dst_hi   = (in_dst_len != 8'd0) ? q_dst[127:64] : 64'd0;
        key.dst_lo   = (in_dst_len != 8'd0) ? q_dst[63:0] : 64'd0;
        key.iface    = item_reg[289:274];
        key.onlink   = !in_has_gw;
        key.gw_hi    = in_has_gw ? item_reg[353:290] : 64'd0;
        key.gw_lo    = in_has_gw ? item_reg[417:354] : 64'd0;
        key.metric   = item_reg[450:419];
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign done_fire = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign wr_en     = done_fire && (op == OP_ADD) && !match_found_reg && free_found_reg;

    srt_route_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (key),
        .rd_addr (cnt_reg[SLOT_W-1:0]),
        .rd_data (cur)
    );

    srt_rank_unit u_rank (
        .op        (op),
        .cur       (cur),
        .top       (best_reg),
        .top_found (best_found_reg),
        .key       (key),
        .q_src     (q_src),
        .q_dst     (q_dst),
        .res       (ev)
    );

    assign slot_live = valid_reg[rd_idx_reg];

    // Sequencer: idle, scan one slot per cycle, then finish into the output register.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((cnt_reg == CNT_W'(ROUTE_SLOTS)) && !rd_v_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result of the finished operation; fields other than status are zero unless a lookup hit.
    always_comb begin
        m_tdata_next = '0;
        if (is_lookup) begin
            if (best_found_reg) begin
                m_tdata_next[1:0]     = ST_OK;
                m_tdata_next[17:2]    = best_reg.iface;
                m_tdata_next[81:18]   = best_reg.gw_hi;
                m_tdata_next[145:82]  = best_reg.gw_lo;
                m_tdata_next[146]     = best_reg.onlink;
                m_tdata_next[178:147] = best_reg.metric;
                m_tdata_next[186:179] = best_reg.dst_len;
                m_tdata_next[194:187] = best_reg.src_len;
            end else begin
                m_tdata_next[1:0] = ST_MISS;
            end
        end else if ((op == OP_ADD) && !match_found_reg && !free_found_reg) begin
            m_tdata_next[1:0] = ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            rd_v_reg        <= 1'b0;
            best_found_reg  <= 1'b0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            valid_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                cnt_reg         <= '0;
                rd_v_reg        <= 1'b0;
                best_found_reg  <= 1'b0;
                free_found_reg  <= 1'b0;
                match_found_reg <= 1'b0;
            end else if (state_reg == S_SCAN) begin
                rd_v_reg <= (cnt_reg != CNT_W'(ROUTE_SLOTS));
                if (cnt_reg != CNT_W'(ROUTE_SLOTS)) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (rd_v_reg) begin
                    if (is_lookup) begin
                        if (slot_live && ev.qualify && ev.better) begin
                            best_found_reg <= 1'b1;
                        end
                    end else begin
                        if (!slot_live && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                        end
                        if (slot_live && ev.same && !match_found_reg) begin
                            match_found_reg <= 1'b1;
                        end
                    end
                end
            end
            if (done_fire) begin
                if ((op == OP_DEL) && match_found_reg) begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
                if (wr_en) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_tdata;
        end
        rd_idx_reg <= cnt_reg[SLOT_W-1:0];
        if ((state_reg == S_SCAN) && rd_v_reg) begin
            if (is_lookup && slot_live && ev.qualify && ev.better) begin
                best_reg <= cur;
            end
            if (!is_lookup && !slot_live && !free_found_reg) begin
                free_idx_reg <= rd_idx_reg;
            end
            if (!is_lookup && slot_live && ev.same && !match_found_reg) begin
                match_idx_reg <= rd_idx_reg;
            end
        end
        if (done_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SRT_ASSERT_NEXT(a_accept_starts_scan, s_fire, (state_reg == S_SCAN) && (cnt_reg == '0), "accepted transfer did not start a scan")
    `SRT_ASSERT_NEXT(a_done_gives_result, done_fire, m_tvalid, "finished operation produced no result")
    `SRT_ASSERT_NEXT(a_add_grows_table, wr_en && !valid_reg[free_idx_reg], $countones(valid_reg) == $past($countones(valid_reg)) + 1, "add did not occupy exactly one slot")
    `SRT_ASSERT_NOW(a_busy_not_ready, state_reg != S_IDLE, !s_tready, "input ready during an operation")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the source-and-destination route table.
`timescale 1ns / 1ps

module testbench;
    import srt_pkg::*;

    // One request as it travels on s_tdata.
    typedef struct {
        logic [1:0]   op;
        logic [63:0]  src_hi, src_lo;
        logic [7:0]   src_len;
        logic [63:0]  dst_hi, dst_lo;
        logic [7:0]   dst_len;
        logic [15:0]  iface;
        logic [63:0]  gw_hi, gw_lo;
        logic         has_gw;
        logic [31:0]  metric;
    } request_t;

    // One reply as it travels on m_tdata.
    typedef struct {
        logic [1:0]   status;
        logic [15:0]  iface;
        logic [63:0]  gw_hi, gw_lo;
        logic         onlink;
        logic [31:0]  metric;
        logic [7:0]   dst_len, src_len;
    } reply_t;

    // Routes held by the table model.
    typedef struct {
        logic [127:0] src, dst, gw;
        logic [7:0]   src_len, dst_len;
        logic [31:0]  metric;
        logic [15:0]  iface;
        logic         onlink;
    } entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    bit       table_used[ROUTE_SLOTS];
    entry_t   table_routes[ROUTE_SLOTS];
    int       error_count = 0;
    bit       quiet_mode = 1'b0;   // when set, neither side idles
    bit       sender_hold = 1'b0;  // when set, the driver holds off new transfers

    // Address pools kept small so that prefixes overlap and lookups hit often.
    logic [127:0] addr_pool[8];

    source_dest_route_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [IN_W-1:0] pack_request(request_t r);
        return {{(IN_W - 451){1'b0}}, r.metric, r.has_gw, r.gw_lo, r.gw_hi, r.iface,
                r.dst_len, r.dst_lo, r.dst_hi, r.src_len, r.src_lo, r.src_hi, r.op};
    endfunction

    function automatic reply_t unpack_reply(logic [OUT_W-1:0] d);
        reply_t r;
        r.status   = d[1:0];
        r.iface    = d[17:2];
        r.gw_hi    = d[81:18];
        r.gw_lo    = d[145:82];
        r.onlink   = d[146];
        r.metric   = d[178:147];
        r.dst_len  = d[186:179];
        r.src_len  = d[194:187];
        return r;
    endfunction

    function automatic bit covers(logic [127:0] pfx, logic [7:0] plen, logic [127:0] addr);
        logic [127:0] mask;
        int n;
        n = (plen > 128) ? 128 : plen;
        mask = '0;
        for (int b = 0; b < n; b++) mask[127 - b] = 1'b1;
        return ((pfx ^ addr) & mask) == '0;
    endfunction

    // Returns 1 when a ranks above b, 0 when identical, -1 when below.
    function automatic int route_order(entry_t a, entry_t b);
        if (a.dst_len != b.dst_len) return a.dst_len > b.dst_len ? 1 : -1;
        if (a.src_len != b.src_len) return a.src_len > b.src_len ? 1 : -1;
        if (a.metric != b.metric) return a.metric < b.metric ? 1 : -1;
        if (a.onlink != b.onlink) return a.onlink ? 1 : -1;
        if (a.iface != b.iface) return a.iface > b.iface ? 1 : -1;
        if (a.src != b.src) return a.src > b.src ? 1 : -1;
        if (a.dst != b.dst) return a.dst > b.dst ? 1 : -1;
        if (a.gw != b.gw) return a.gw > b.gw ? 1 : -1;
        return 0;
    endfunction

    // Applies one request to the table model and returns the reply it must produce.
    function automatic reply_t apply_route_op(request_t q);
        reply_t rep;
        entry_t key, top;
        int best, free_idx, match;
        rep = '{default: '0};
        best = -1;
        free_idx = -1;
        match = -1;
        if (q.op == OP_LOOKUP_SRC || q.op == OP_LOOKUP_ANY) begin
            for (int i = 0; i < ROUTE_SLOTS; i++) begin
                if (!table_used[i]) continue;
                if (!covers(table_routes[i].dst, table_routes[i].dst_len,
                            {q.dst_hi, q.dst_lo})) continue;
                if (q.op == OP_LOOKUP_SRC && !covers(table_routes[i].src,
                        table_routes[i].src_len, {q.src_hi, q.src_lo})) continue;
                if (best < 0 || route_order(table_routes[i], top) > 0) begin
                    best = i;
                    top = table_routes[i];
                end
            end
            if (best < 0) begin
                rep.status = ST_MISS;
            end else begin
                rep.status = ST_OK;
                rep.iface = top.iface;
                {rep.gw_hi, rep.gw_lo} = top.gw;
                rep.onlink = top.onlink;
                rep.metric = top.metric;
                rep.dst_len = top.dst_len;
                rep.src_len = top.src_len;
            end
            return rep;
        end
        key.src_len = q.src_len;
        key.dst_len = q.dst_len;
        key.src = q.src_len != 0 ? {q.src_hi, q.src_lo} : '0;
        key.dst = q.dst_len != 0 ? {q.dst_hi, q.dst_lo} : '0;
        key.iface = q.iface;
        key.onlink = ~q.has_gw;
        key.gw = q.has_gw ? {q.gw_hi, q.gw_lo} : '0;
        key.metric = q.metric;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (!table_used[i]) begin
                if (free_idx < 0) free_idx = i;
            end else if (match < 0 && route_order(table_routes[i], key) == 0) begin
                match = i;
            end
        end
        if (q.op == OP_DEL) begin
            if (match >= 0) table_used[match] = 1'b0;
        end else if (match < 0) begin
            if (free_idx < 0) begin
                rep.status = ST_FULL;
            end else begin
                table_used[free_idx] = 1'b1;
                table_routes[free_idx] = key;
            end
        end
        return rep;
    endfunction

    function automatic request_t random_request(logic [1:0] op);
        request_t r;
        logic [127:0] a;
        r.op = op;
        a = addr_pool[$urandom_range(7)];
        {r.src_hi, r.src_lo} = ($urandom_range(3) == 0) ?
            {$urandom, $urandom, $urandom, $urandom} : a;
        a = addr_pool[$urandom_range(7)];
        {r.dst_hi, r.dst_lo} = ($urandom_range(3) == 0) ?
            {$urandom, $urandom, $urandom, $urandom} : a;
        case ($urandom_range(9))
            0: r.src_len = 8'd0;
            1: r.src_len = 8'($urandom_range(255));
            default: r.src_len = 8'($urandom_range(128));
        endcase
        case ($urandom_range(9))
            0: r.dst_len = 8'd0;
            1: r.dst_len = 8'($urandom_range(255));
            default: r.dst_len = 8'($urandom_range(128));
        endcase
        r.iface = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
        {r.gw_hi, r.gw_lo} = {$urandom, $urandom, $urandom, $urandom};
        r.has_gw = 1'($urandom_range(1));
        r.metric = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom;
        return r;
    endfunction

    // Driver: raises s_tvalid with the next pending request and holds it until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && !sender_hold &&
                    (quiet_mode || $urandom_range(99) >= 6)) begin
                    s_tdata <= pack_request(pending_reqs[0]);
                    expected_replies.push_back(apply_route_op(pending_reqs[0]));
                    void'(pending_reqs.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: toggles m_tready at random and checks every reply transfer.
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn) begin
            m_tready <= quiet_mode || ($urandom_range(99) >= 6);
            if (m_tvalid && m_tready) begin
                got = unpack_reply(m_tdata);
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply %p", $time, got);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status || got.iface != want.iface ||
                        got.gw_hi != want.gw_hi || got.gw_lo != want.gw_lo ||
                        got.onlink != want.onlink || got.metric != want.metric ||
                        got.dst_len != want.dst_len || got.src_len != want.src_len) begin
                        $display("%0t: reply mismatch, expected %p, actual %p",
                                 $time, want, got);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus: directed corner cases, then random route churn with lookups.
    initial begin
        request_t r;
        int pick;
        for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes: all-zero and all-one fields, zero and oversized prefix lengths.
        r = '{op: OP_LOOKUP_ANY, default: '0};
        pending_reqs.push_back(r);                              // miss on empty table
        r = '{op: OP_ADD, src_len: 8'd0, dst_len: 8'd0, default: '1};
        r.has_gw = 1'b0;                                        // on-link, zeroed fields
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);                              // identical add
        r.op = OP_LOOKUP_SRC;
        pending_reqs.push_back(r);
        r = '{op: OP_ADD, src_len: 8'd255, dst_len: 8'd128, has_gw: 1'b1, default: '1};
        pending_reqs.push_back(r);
        r.op = OP_LOOKUP_SRC;
        pending_reqs.push_back(r);
        r.op = OP_LOOKUP_ANY;
        r.dst_lo[0] = 1'b0;                                     // falls back to default
        pending_reqs.push_back(r);
        r = '{op: OP_ADD, src_len: 8'd64, dst_len: 8'd64, metric: 32'd5,
              has_gw: 1'b1, default: '1};
        r.dst_lo = 64'h1234;                                    // bits past the length
        pending_reqs.push_back(r);
        r.op = OP_LOOKUP_ANY;
        r.dst_lo = '0;
        pending_reqs.push_back(r);
        r.op = OP_DEL;
        r.dst_lo = 64'h1234;
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);                              // delete with no match
        // Fill the table to the brim on top of the two routes it holds; the last three adds report full.
        for (int i = 0; i < ROUTE_SLOTS + 1; i++) begin
            r = random_request(OP_ADD);
            r.metric = 32'd1000 + i;
            pending_reqs.push_back(r);
        end
        r = random_request(OP_LOOKUP_ANY);
        pending_reqs.push_back(r);

        // Wait until the table is idle before the random part.
        wait (pending_reqs.size() == 0 && expected_replies.size() == 0);
        // Clear the table by deleting everything the model holds.
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (table_used[i]) begin
                r.op = OP_DEL;
                {r.src_hi, r.src_lo} = table_routes[i].src;
                {r.dst_hi, r.dst_lo} = table_routes[i].dst;
                r.src_len = table_routes[i].src_len;
                r.dst_len = table_routes[i].dst_len;
                r.iface = table_routes[i].iface;
                {r.gw_hi, r.gw_lo} = table_routes[i].gw;
                r.has_gw = ~table_routes[i].onlink;
                r.metric = table_routes[i].metric;
                pending_reqs.push_back(r);
            end
        end

        for (int n = 0; n < 2000; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) r = random_request(OP_ADD);
            else if (pick < 50) r = random_request(OP_DEL);
            else if (pick < 75) r = random_request(OP_LOOKUP_SRC);
            else r = random_request(OP_LOOKUP_ANY);
            pending_reqs.push_back(r);
            if (n == 600) begin
                // Let the sender drain, then hold off until every reply arrives.
                wait (pending_reqs.size() == 0);
                sender_hold = 1'b1;
                wait (expected_replies.size() == 0);
                sender_hold = 1'b0;
            end
            if (n == 900) quiet_mode = 1'b1;
            if (n == 1300) quiet_mode = 1'b0;
            while (pending_reqs.size() > 4) @(posedge aclk);
        end

        wait (pending_reqs.size() == 0 && expected_replies.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog well beyond the slowest run.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_route_mem.sv
rtl/srt_rank_unit.sv
rtl/source_dest_route_table_top.sv
tb/testbench.sv
